// ===== design/indoor_air_quality_index_macros.svh =====
// assertion macros used by the air quality index top level
// depends on a clock named clk and an active-low reset named rst_n in the including module
`ifndef INDOOR_AIR_QUALITY_INDEX_MACROS_SVH
`define INDOOR_AIR_QUALITY_INDEX_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked at every clock edge outside reset
`define IAQI_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iaqi assertion failed");

// next-cycle implication
`define IAQI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iaqi assertion failed");

`else

`define IAQI_ASSERT_NOW(lbl, ante, cons)
`define IAQI_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== design/iaqi_pkg.sv =====
// shared types, threshold sets, comfort table and helper functions
// for the indoor air quality index; no dependencies
package iaqi_pkg;

    localparam int GRADE_W     = 3;
    localparam int GRADE_MIN   = 1;
    localparam int GRADE_MAX   = 6;
    localparam int LIMIT_COUNT = 5;
    localparam int LIMIT_W     = 16;
    localparam int ROW_COUNT   = 9;
    localparam int COL_COUNT   = 13;
    localparam int ROW_W       = $clog2(ROW_COUNT);
    localparam int COL_W       = $clog2(COL_COUNT);

    typedef logic [GRADE_W-1:0] grade_t;
    typedef logic [0:LIMIT_COUNT-1][LIMIT_W-1:0] limit_set_t;
    typedef logic [ROW_W-1:0] row_t;
    typedef logic [COL_W-1:0] col_t;

    // grades from the threshold grader
    typedef struct packed {
        grade_t co2;
        grade_t tvoc;
        grade_t particle;
    } sub_grades_t;

    // thresholds, highest first; strictly above earns grade 6 down to 2
    localparam limit_set_t CO2_LIMITS  = '{16'd5000, 16'd2000, 16'd1500, 16'd1000, 16'd400};
    localparam limit_set_t TVOC_LIMITS = '{16'd5000, 16'd1500, 16'd500, 16'd150, 16'd50};
    localparam limit_set_t PM25_LIMITS = '{16'd250, 16'd150, 16'd55, 16'd35, 16'd12};
    localparam limit_set_t PM10_LIMITS = '{16'd425, 16'd355, 16'd255, 16'd155, 16'd55};

    // comfort table, row = humidity band, column = temperature 16..28
    localparam grade_t CLIMATE_TABLE [0:ROW_COUNT-1][0:COL_COUNT-1] = '{
        '{3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6},
        '{3'd6, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd6},
        '{3'd6, 3'd5, 3'd5, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd5, 3'd6},
        '{3'd6, 3'd5, 3'd5, 3'd4, 3'd3, 3'd3, 3'd3, 3'd2, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6},
        '{3'd5, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd1, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6},
        '{3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6},
        '{3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd1, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd5, 3'd6},
        '{3'd5, 3'd4, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd4, 3'd5, 3'd5, 3'd5, 3'd6},
        '{3'd6, 3'd5, 3'd4, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd5, 3'd5, 3'd6, 3'd6, 3'd6}
    };

    // first threshold strictly exceeded picks the grade, else best grade
    function automatic grade_t grade_of(input logic [LIMIT_W-1:0] value,
                                        input limit_set_t lims);
        grade_t g;
        g = grade_t'(GRADE_MIN);
        for (int i = LIMIT_COUNT - 1; i >= 0; i--)
        begin
            if (value > lims[i])
            begin
                g = grade_t'(GRADE_MAX - i);
            end
        end
        return g;
    endfunction

    function automatic grade_t max_grade(input grade_t a, input grade_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ===== design/iaqi_thresh.sv =====
// threshold grading of co2, tvoc and particle readings
// depends on iaqi_pkg
module iaqi_thresh (
    input  logic [15:0]          co2_ppm,
    input  logic [15:0]          tvoc_ppb,
    input  logic [9:0]           pm2p5_ugm3,
    input  logic [9:0]           pm10_ugm3,
    output iaqi_pkg::sub_grades_t grades
);
    import iaqi_pkg::*;

    grade_t pm25_grade;
    grade_t pm10_grade;

    // per-sensor grades against fixed thresholds
    assign pm25_grade = grade_of(LIMIT_W'(pm2p5_ugm3), PM25_LIMITS);
    assign pm10_grade = grade_of(LIMIT_W'(pm10_ugm3), PM10_LIMITS);

    // particle grade is the worse of the two sizes
    always_comb
    begin
        grades.co2      = grade_of(co2_ppm, CO2_LIMITS);
        grades.tvoc     = grade_of(tvoc_ppb, TVOC_LIMITS);
        grades.particle = max_grade(pm25_grade, pm10_grade);
    end

endmodule

// ===== design/iaqi_climate.sv =====
// climate comfort grade from humidity band and temperature
// depends on iaqi_pkg
module iaqi_climate (
    input  logic [6:0]        humidity_pct,
    input  logic signed [7:0] temperature_c,
    output iaqi_pkg::grade_t  climate_grade
);
    import iaqi_pkg::*;

    row_t row;
    col_t col;

    // humidity / 10 clamped to 1..9, minus 1: count bands 20, 30 .. 90
    always_comb
    begin
        row = '0;
        for (int i = 1; i < ROW_COUNT; i++)
        begin
            if (humidity_pct >= 7'((i + 1) * 10))
            begin
                row = row_t'(i);
            end
        end
    end

    // temperature clamped to 16..28, minus 16
    always_comb
    begin
        if (temperature_c < 8'sd16)
        begin
            col = '0;
        end
        else if (temperature_c > 8'sd28)
        begin
            col = col_t'(COL_COUNT - 1);
        end
        else
        begin
            col = col_t'(temperature_c - 8'sd16);
        end
    end

    // table lookup
    assign climate_grade = CLIMATE_TABLE[row][col];

endmodule

// ===== design/indoor_air_quality_index.sv =====
// indoor air quality index top level: input register, grading logic, result register
// throughput one transaction per cycle while index_stall holds no pending result, set by
// the single pass of compares and table lookup between the two registers
// rst_n clears both valid flags asynchronously; payload registers are not reset
// depends on iaqi_pkg, iaqi_thresh, iaqi_climate and indoor_air_quality_index_macros.svh
`include "indoor_air_quality_index_macros.svh"

module indoor_air_quality_index (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 readings_valid,
    output logic                 readings_stall,
    input  logic [15:0]          co2_ppm,
    input  logic [15:0]          tvoc_ppb,
    input  logic [6:0]           humidity_pct,
    input  logic signed [7:0]    temperature_c,
    input  logic [9:0]           pm2p5_ugm3,
    input  logic [9:0]           pm10_ugm3,
    output logic                 index_valid,
    input  logic                 index_stall,
    output iaqi_pkg::grade_t     overall_index,
    output iaqi_pkg::grade_t     co2_grade,
    output iaqi_pkg::grade_t     tvoc_grade,
    output iaqi_pkg::grade_t     climate_grade,
    output iaqi_pkg::grade_t     particle_grade
);
    import iaqi_pkg::*;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [15:0]       co2_reg;
    logic [15:0]       tvoc_reg;
    logic [6:0]        hum_reg;
    logic signed [7:0] temp_reg;
    logic [9:0]        pm25_reg;
    logic [9:0]        pm10_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    grade_t            overall_reg;
    grade_t            co2_reg_g;
    grade_t            tvoc_reg_g;
    grade_t            climate_reg;
    grade_t            particle_reg;

    logic              accept;
    logic              advance;
    sub_grades_t       grades;
    grade_t            clim_grade;
    grade_t            overall;

    // handshake: input stage moves on when the result register is free or being taken
    assign advance        = !out_valid_reg || !index_stall;
    assign readings_stall = in_valid_reg && !advance;
    assign accept         = readings_valid && !readings_stall;

    always_comb
    begin
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            co2_reg  <= co2_ppm;
            tvoc_reg <= tvoc_ppb;
            hum_reg  <= humidity_pct;
            temp_reg <= temperature_c;
            pm25_reg <= pm2p5_ugm3;
            pm10_reg <= pm10_ugm3;
        end
    end

    // grading logic
    iaqi_thresh u_thresh (
        .co2_ppm    (co2_reg),
        .tvoc_ppb   (tvoc_reg),
        .pm2p5_ugm3 (pm25_reg),
        .pm10_ugm3  (pm10_reg),
        .grades     (grades)
    );

    iaqi_climate u_climate (
        .humidity_pct  (hum_reg),
        .temperature_c (temp_reg),
        .climate_grade (clim_grade)
    );

    // overall index is the worst sub-grade
    assign overall = max_grade(max_grade(grades.co2, grades.tvoc),
                               max_grade(clim_grade, grades.particle));

    // result register
    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            overall_reg  <= overall;
            co2_reg_g    <= grades.co2;
            tvoc_reg_g   <= grades.tvoc;
            climate_reg  <= clim_grade;
            particle_reg <= grades.particle;
        end
    end

    assign index_valid    = out_valid_reg;
    assign overall_index  = overall_reg;
    assign co2_grade      = co2_reg_g;
    assign tvoc_grade     = tvoc_reg_g;
    assign climate_grade  = climate_reg;
    assign particle_grade = particle_reg;

    // checks
    `IAQI_ASSERT_NOW(a_overall_is_max, index_valid,
        overall_index >= co2_grade && overall_index >= tvoc_grade &&
        overall_index >= climate_grade && overall_index >= particle_grade)
    `IAQI_ASSERT_NOW(a_overall_is_sub, index_valid,
        overall_index == co2_grade || overall_index == tvoc_grade ||
        overall_index == climate_grade || overall_index == particle_grade)
    `IAQI_ASSERT_NOW(a_climate_range, index_valid,
        climate_grade >= 3'(GRADE_MIN) && climate_grade <= 3'(GRADE_MAX))
    `IAQI_ASSERT_NEXT(a_pending_kept, in_valid_reg && !advance, in_valid_reg && index_valid)

endmodule
